[src/gfc_pkg.sv]
// shared field widths and command codes for the greedy face colouring core
package gfc_pkg;

	localparam int CMD_W   = 2;
	localparam int CELL_W  = 11;
	localparam int SLOT_W  = 3;
	localparam int FACE_W  = 12;
	localparam int COUNT_W = 4;
	localparam int COLOR_W = 4;
	localparam int CCNT_W  = 5;

	localparam int IN_DATA_W  = 56;
	localparam int OUT_DATA_W = 24;

	typedef enum logic [CMD_W-1:0] {
		CMD_CLEAR = 2'd0,
		CMD_SLOT  = 2'd1,
		CMD_COUNT = 2'd2,
		CMD_COLOR = 2'd3
	} cmd_t;

endpackage

[src/greedy_face_coloring_core.sv]
// First-fit face colouring core.
// A command beat enters on the slave stream (s_tvalid/s_tready), command code in
// s_tuser. Clear marks every face uncoloured, slot and count writes load a cell's
// face list, colour gives one face the lowest colour not held by the other
// coloured faces of its owner and neighbour cells. Every command returns exactly
// one result beat on the master stream; m_tuser flags a beat that carries a colour.
// Steps: slot and count writes go from acceptance straight to the result state; a
// colour command runs the count read, the slot scan, the drain and the pick, with the
// cell face-slot memory port read one slot a cycle, feeding a face-colour memory
// read in the next cycle; a clear sweeps the face-colour memory one row per cycle.
// s_tready returns together with the result beat.
// Work is one command at a time; a command is taken while the previous result
// still sits in the output register, and waits for that register to drain.
// After reset a clearing pass over every face-colour and cell-count address zeroes
// the face-colour flags and the cell face counts; s_tready stays low until it ends.
// A stalled master holds its beat; the core keeps working on the next command.
module greedy_face_coloring_core #(
	parameter int MAX_FACES      = 4096,
	parameter int MAX_CELLS      = 2048,
	parameter int FACES_PER_CELL = 8,
	parameter int NUM_COLORS     = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// cell_index, slot_index, face_index, face_count, owner_cell, owner_valid,
	// neighbor_cell, neighbor_valid, zero pad
	input  logic [gfc_pkg::IN_DATA_W-1:0]    s_tdata,
	// command
	input  logic [gfc_pkg::CMD_W-1:0]        s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// result_face, colour, color_count, zero pad
	output logic [gfc_pkg::OUT_DATA_W-1:0]   m_tdata,
	// colored
	output logic                             m_tuser
);

	localparam int FA_W    = $clog2(MAX_FACES);
	localparam int CE_W    = $clog2(MAX_CELLS);
	localparam int FPC_W   = $clog2(FACES_PER_CELL);
	localparam int CNT_W   = $clog2(FACES_PER_CELL + 1);
	localparam int CL_W    = $clog2(NUM_COLORS);
	localparam int HC_W    = $clog2(NUM_COLORS + 1);
	localparam int SWEEP_N = (MAX_FACES > MAX_CELLS) ? MAX_FACES : MAX_CELLS;
	localparam int SW_W    = $clog2(SWEEP_N);
	localparam int SA_W    = CE_W + FPC_W;

	typedef enum logic [2:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_CNT,
		ST_CWAIT,
		ST_SCAN,
		ST_DRAIN,
		ST_PICK,
		ST_RES
	} state_t;

	// input beat fields
	logic [gfc_pkg::CELL_W-1:0]  in_cell;
	logic [gfc_pkg::SLOT_W-1:0]  in_slot;
	logic [gfc_pkg::FACE_W-1:0]  in_face;
	logic [gfc_pkg::COUNT_W-1:0] in_count;
	logic [gfc_pkg::CELL_W-1:0]  in_owner;
	logic                        in_owner_ok;
	logic [gfc_pkg::CELL_W-1:0]  in_nbr;
	logic                        in_nbr_ok;
	gfc_pkg::cmd_t               in_cmd;

	assign in_cell     = s_tdata[10:0];
	assign in_slot     = s_tdata[13:11];
	assign in_face     = s_tdata[25:14];
	assign in_count    = s_tdata[29:26];
	assign in_owner    = s_tdata[40:30];
	assign in_owner_ok = s_tdata[41];
	assign in_nbr      = s_tdata[52:42];
	assign in_nbr_ok   = s_tdata[53];
	assign in_cmd      = gfc_pkg::cmd_t'(s_tuser);

	// memories: face word is {coloured, colour}
	logic [CL_W:0]                face_mem_q [MAX_FACES];
	logic [gfc_pkg::FACE_W-1:0]   slot_mem_q [MAX_CELLS << FPC_W];
	logic [CNT_W-1:0]             cnt_mem_q  [MAX_CELLS];

	logic                         fm_we;
	logic [FA_W-1:0]              fm_wa;
	logic [CL_W:0]                fm_wd;
	logic [FA_W-1:0]              fm_ra;
	logic [CL_W:0]                fm_rd_q;

	logic                         sm_we;
	logic [SA_W-1:0]              sm_wa;
	logic [SA_W-1:0]              sm_ra;
	logic [gfc_pkg::FACE_W-1:0]   sm_rd_q;

	logic                         cm_we;
	logic [CE_W-1:0]              cm_wa;
	logic [CNT_W-1:0]             cm_wd;
	logic [CE_W-1:0]              cm_ra;
	logic [CNT_W-1:0]             cm_rd_q;

	// control and datapath registers
	state_t                       state_q;
	logic [SW_W-1:0]              sweep_idx_q;
	logic                         sweep_cells_q;
	logic [gfc_pkg::FACE_W-1:0]   face_q;
	logic [CE_W-1:0]              cell_a_q;
	logic [CE_W-1:0]              cell_b_q;
	logic                         ok_a_q;
	logic                         ok_b_q;
	logic                         pass_q;
	logic [CNT_W-1:0]             n_q;
	logic [CNT_W-1:0]             k_q;
	logic                         valid_s1;
	logic                         valid_s2;
	logic [NUM_COLORS-1:0]        used_q;
	logic [HC_W-1:0]              hcp1_q;
	logic                         res_colored_q;
	logic [gfc_pkg::FACE_W-1:0]   res_face_q;
	logic [CL_W-1:0]              res_color_q;
	logic                         out_valid_q;
	logic                         out_colored_q;
	logic [gfc_pkg::FACE_W-1:0]   out_face_q;
	logic [gfc_pkg::COLOR_W-1:0]  out_color_q;
	logic [gfc_pkg::CCNT_W-1:0]   out_count_q;

	logic                         accept;
	logic                         out_free;
	logic [CE_W-1:0]              cur_cell;
	logic                         cur_ok;
	logic                         scan_issue;
	logic                         face_issue;
	logic                         sweep_last;
	logic                         pick_found;
	logic [CL_W-1:0]              pick_color;
	logic [HC_W-1:0]              pick_plus1;
	logic [CNT_W-1:0]             sat_count;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_colored_q;
	assign m_tdata  = {3'b000, out_count_q, out_color_q, out_face_q};

	assign cur_cell   = pass_q ? cell_b_q : cell_a_q;
	assign cur_ok     = pass_q ? ok_b_q : ok_a_q;
	assign scan_issue = (state_q == ST_SCAN) && (k_q < n_q);
	// slot data is back: skip the face itself and faces beyond the table
	assign face_issue = valid_s1 && (sm_rd_q != face_q) && (32'(sm_rd_q) < MAX_FACES);
	assign sweep_last = sweep_cells_q ? (sweep_idx_q == SW_W'(SWEEP_N - 1))
	                                  : (sweep_idx_q == SW_W'(MAX_FACES - 1));
	assign sat_count  = (32'(in_count) > FACES_PER_CELL) ? CNT_W'(FACES_PER_CELL)
	                                                     : CNT_W'(in_count);
	assign pick_plus1 = HC_W'(pick_color) + HC_W'(1);

	// lowest free colour
	always_comb begin
		pick_found = 1'b0;
		pick_color = '0;
		for (int c = NUM_COLORS - 1; c >= 0; c--) begin
			if (!used_q[c]) begin
				pick_found = 1'b1;
				pick_color = CL_W'(c);
			end
		end
	end

	// memory port steering
	always_comb begin
		fm_we = 1'b0;
		fm_wa = '0;
		fm_wd = '0;
		if (state_q == ST_SWEEP) begin
			fm_we = (32'(sweep_idx_q) < MAX_FACES);
			fm_wa = FA_W'(sweep_idx_q);
		end else if (state_q == ST_PICK) begin
			fm_we = pick_found;
			fm_wa = FA_W'(face_q);
			fm_wd = {1'b1, pick_color};
		end
		fm_ra = FA_W'(sm_rd_q);

		sm_we = accept && (in_cmd == gfc_pkg::CMD_SLOT) && (32'(in_cell) < MAX_CELLS)
		        && (32'(in_slot) < FACES_PER_CELL);
		sm_wa = {CE_W'(in_cell), FPC_W'(in_slot)};
		sm_ra = {cur_cell, FPC_W'(k_q)};

		cm_we = 1'b0;
		cm_wa = '0;
		cm_wd = '0;
		if (state_q == ST_SWEEP) begin
			cm_we = sweep_cells_q && (32'(sweep_idx_q) < MAX_CELLS);
			cm_wa = CE_W'(sweep_idx_q);
		end else if (accept && (in_cmd == gfc_pkg::CMD_COUNT)) begin
			cm_we = (32'(in_cell) < MAX_CELLS);
			cm_wa = CE_W'(in_cell);
			cm_wd = sat_count;
		end
		cm_ra = cur_cell;
	end

	always_ff @(posedge clk) begin
		if (fm_we) begin
			face_mem_q[fm_wa] <= fm_wd;
		end
		fm_rd_q <= face_mem_q[fm_ra];
	end

	always_ff @(posedge clk) begin
		if (sm_we) begin
			slot_mem_q[sm_wa] <= in_face;
		end
		sm_rd_q <= slot_mem_q[sm_ra];
	end

	always_ff @(posedge clk) begin
		if (cm_we) begin
			cnt_mem_q[cm_wa] <= cm_wd;
		end
		cm_rd_q <= cnt_mem_q[cm_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_SWEEP;
			sweep_idx_q   <= '0;
			sweep_cells_q <= 1'b1;
			face_q        <= '0;
			cell_a_q      <= '0;
			cell_b_q      <= '0;
			ok_a_q        <= 1'b0;
			ok_b_q        <= 1'b0;
			pass_q        <= 1'b0;
			n_q           <= '0;
			k_q           <= '0;
			valid_s1      <= 1'b0;
			valid_s2      <= 1'b0;
			used_q        <= '0;
			hcp1_q        <= '0;
			res_colored_q <= 1'b0;
			res_face_q    <= '0;
			res_color_q   <= '0;
			out_valid_q   <= 1'b0;
			out_colored_q <= 1'b0;
			out_face_q    <= '0;
			out_color_q   <= '0;
			out_count_q   <= '0;
		end else begin
			// slot read -> face read -> merge pipeline
			valid_s1 <= scan_issue;
			valid_s2 <= face_issue;
			if (valid_s2 && fm_rd_q[CL_W]) begin
				used_q[fm_rd_q[CL_W-1:0]] <= 1'b1;
			end

			// the result state reloads the register itself when the beat leaves
			if (out_valid_q && m_tready && (state_q != ST_RES)) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_SWEEP: begin
					if (sweep_last) begin
						sweep_idx_q   <= '0;
						sweep_cells_q <= 1'b0;
						state_q       <= sweep_cells_q ? ST_IDLE : ST_RES;
					end else begin
						sweep_idx_q <= sweep_idx_q + SW_W'(1);
					end
				end
				ST_IDLE: begin
					if (accept) begin
						res_colored_q <= 1'b0;
						res_face_q    <= '0;
						res_color_q   <= '0;
						face_q        <= in_face;
						cell_a_q      <= CE_W'(in_owner);
						cell_b_q      <= CE_W'(in_nbr);
						ok_a_q        <= in_owner_ok && (32'(in_owner) < MAX_CELLS);
						ok_b_q        <= in_nbr_ok && (32'(in_nbr) < MAX_CELLS);
						pass_q        <= 1'b0;
						used_q        <= '0;
						unique case (in_cmd)
							gfc_pkg::CMD_CLEAR: begin
								hcp1_q  <= '0;
								state_q <= ST_SWEEP;
							end
							gfc_pkg::CMD_SLOT,
							gfc_pkg::CMD_COUNT: begin
								state_q <= ST_RES;
							end
							gfc_pkg::CMD_COLOR: begin
								state_q <= (32'(in_face) < MAX_FACES) ? ST_CNT : ST_RES;
							end
							default: begin
								state_q <= ST_RES;
							end
						endcase
					end
				end
				ST_CNT: begin
					priority if (cur_ok) begin
						state_q <= ST_CWAIT;
					end else if (!pass_q) begin
						pass_q <= 1'b1;
					end else begin
						state_q <= ST_DRAIN;
					end
				end
				ST_CWAIT: begin
					n_q     <= cm_rd_q;
					k_q     <= '0;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (scan_issue) begin
						k_q <= k_q + CNT_W'(1);
					end else if (!pass_q) begin
						pass_q  <= 1'b1;
						state_q <= ST_CNT;
					end else begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!valid_s1 && !valid_s2) begin
						state_q <= ST_PICK;
					end
				end
				ST_PICK: begin
					if (pick_found) begin
						res_colored_q <= 1'b1;
						res_face_q    <= face_q;
						res_color_q   <= pick_color;
						if (pick_plus1 > hcp1_q) begin
							hcp1_q <= pick_plus1;
						end
					end
					state_q <= ST_RES;
				end
				ST_RES: begin
					if (out_free) begin
						out_valid_q   <= 1'b1;
						out_colored_q <= res_colored_q;
						out_face_q    <= res_face_q;
						out_color_q   <= gfc_pkg::COLOR_W'(res_color_q);
						out_count_q   <= gfc_pkg::CCNT_W'(hcp1_q);
						state_q       <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTH
	// a result beat is only loaded from the result state
	a_out_from_res: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_RES))
		else $error("result beat raised outside result state");

	// a coloured result lies below the running colour count
	a_color_below_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_colored_q) |->
		({1'b0, out_color_q} < out_count_q))
		else $error("chosen colour not below colour count");

	// the read pipeline is empty whenever a new command may enter
	a_pipe_empty_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (!valid_s1 && !valid_s2))
		else $error("read pipeline busy in idle");

	// the colour count never passes the palette size
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(hcp1_q) <= NUM_COLORS)
		else $error("colour count above palette size");

	// a pick only follows a drained pipeline
	a_pick_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PICK) |-> $past(state_q == ST_DRAIN))
		else $error("pick entered without drain");
`endif

endmodule
